@@ rtl/core/svtn_pkg.sv @@
// ---------------------------------------------------------------------------
// svtn_pkg
// Shared types, register map and envelope shape logic for the six-voice
// tone/noise/envelope synthesiser core.
// ---------------------------------------------------------------------------
`default_nettype none

package svtn_pkg;

  localparam int PHASE_BITS_DEF     = 24;
  localparam int SAMPLE_RATE_HZ_DEF = 22050;

  // voice frequency base (Hz) before octave shift
  localparam int FREQ_BASE = 31250;
  localparam int FREQ_BASE_W = 15;
  localparam int OCT_SHIFT_MAX_W = 7;

  // fixed noise rates (Hz)
  localparam longint NOISE_HZ0 = 62500;
  localparam longint NOISE_HZ1 = 31250;
  localparam longint NOISE_HZ2 = 15624;

  // divide by six: floor(x * RECIP6 >> RECIP6_SH), exact for x < 2^21
  localparam int RECIP6_W  = 20;
  localparam logic [RECIP6_W-1:0] RECIP6 = 20'd699051;
  localparam int RECIP6_SH = 22;

  // request opcodes
  localparam logic [1:0] OP_SEL  = 2'd0;
  localparam logic [1:0] OP_WR   = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  // register map
  localparam logic [4:0] REG_AMP_LAST  = 5'h05;
  localparam logic [4:0] REG_FREQ0     = 5'h08;
  localparam logic [4:0] REG_FREQ_LAST = 5'h0D;
  localparam logic [4:0] REG_OCT0      = 5'h10;
  localparam logic [4:0] REG_OCT_LAST  = 5'h12;
  localparam logic [4:0] REG_TONE_EN   = 5'h14;
  localparam logic [4:0] REG_NOISE_EN  = 5'h15;
  localparam logic [4:0] REG_NRATE     = 5'h16;
  localparam logic [4:0] REG_ENV0      = 5'h18;
  localparam logic [4:0] REG_ENV1      = 5'h19;
  localparam logic [4:0] REG_MIX       = 5'h1C;

  // envelope control bits
  localparam int ECTL_REV = 0;
  localparam int ECTL_B3  = 4;
  localparam int ECTL_EXT = 5;
  localparam int ECTL_EN  = 6;

  // noise rate select: follow the group's first voice
  localparam logic [1:0] NSEL_VOICE = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [5:0] pos;
    logic [9:0] lev;
  } env_upd_t;

  function automatic logic [3:0] env_shape(input logic [2:0] mode, input logic [5:0] p);
    logic [3:0] lo;
    logic [3:0] res;
    lo = p[3:0];
    case (mode)
      3'd0: res = 4'd0;
      3'd1: res = 4'd15;
      3'd2: res = (p < 6'd16) ? 4'd15 - lo : 4'd0;
      3'd3: res = 4'd15 - lo;
      3'd4: res = p[5] ? 4'd0 : (p[4] ? 4'd15 - lo : lo);
      3'd5: res = p[4] ? 4'd15 - lo : lo;
      3'd6: res = (p < 6'd16) ? lo : 4'd0;
      default: res = lo;
    endcase
    return res;
  endfunction

  function automatic env_upd_t env_advance(input logic [6:0] ctl, input logic [5:0] pos);
    env_upd_t   u;
    logic [5:0] np;
    logic [3:0] shp;
    logic [3:0] msk;
    logic [3:0] rv;
    np  = (pos == 6'd63) ? 6'd32 : pos + 6'd1;
    shp = env_shape(ctl[3:1], np);
    msk = ctl[ECTL_B3] ? 4'd14 : 4'd15;
    rv  = ctl[ECTL_REV] ? 4'd15 - shp : shp;
    if (!ctl[ECTL_EN]) begin
      u.pos = pos;
      u.lev = {5'd16, 5'd16};
    end else begin
      u.pos = np;
      u.lev = {1'b0, rv & msk, 1'b0, shp & msk};
    end
    return u;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/svtn_div.sv @@
// ---------------------------------------------------------------------------
// svtn_div
// Restoring divider, one quotient bit per cycle; keeps the low Q_W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module svtn_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 24,
  parameter int Q_W   = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output svtn_pkg::div_stat_t   stat,
  output logic      [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] nsh_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, nsh_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      nsh_r <= {nsh_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_r   <= {q_r[Q_W-2:0], fits};
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

`default_nettype wire

@@ rtl/core/six_voice_tone_noise_envelope_synth_core.sv @@
// ---------------------------------------------------------------------------
// six_voice_tone_noise_envelope_synth_core
// Six square-wave voices, two XNOR noise registers and two envelope units,
// programmed by address/data requests; each tick request yields one stereo
// sample.
// ---------------------------------------------------------------------------
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+-----------
//  in      | in_valid, in_stall, in_opcode, in_value | sink
//  out     | out_valid, out_stall, out_left_sample, | source
//          | out_right_sample                       |
//
//  Address and data requests are taken in the idle state. In a tick with the
//  mix enabled, each voice's phase increment comes from the one shared
//  serial divider (NUM_W = 22 + PHASE_BITS), one quotient bit per cycle; a
//  tick with the mix off does not use the divider.
//  in_stall is high while a tick is being worked; a finished sample sits in
//  the output register and the core waits there only if it is still full.
//  Reset is synchronous, active low, and clears all programmed state.
//
`default_nettype none

module six_voice_tone_noise_envelope_synth_core #(
  parameter int PHASE_BITS     = svtn_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_RATE_HZ = svtn_pkg::SAMPLE_RATE_HZ_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [7:0]        in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [15:0]     out_left_sample,
  output logic signed [15:0]     out_right_sample
);

  localparam int PB    = PHASE_BITS;
  localparam int NUM_W = svtn_pkg::FREQ_BASE_W + svtn_pkg::OCT_SHIFT_MAX_W + PB;
  localparam int DEN_W = 9 + $clog2(SAMPLE_RATE_HZ + 1);
  localparam int SUM_W = 21;
  localparam int PRD_W = SUM_W + svtn_pkg::RECIP6_W;

  // fixed noise increments, worked out at elaboration
  localparam logic [63:0] NINC0 = (svtn_pkg::NOISE_HZ0 << PB) / SAMPLE_RATE_HZ;
  localparam logic [63:0] NINC1 = (svtn_pkg::NOISE_HZ1 << PB) / SAMPLE_RATE_HZ;
  localparam logic [63:0] NINC2 = (svtn_pkg::NOISE_HZ2 << PB) / SAMPLE_RATE_HZ;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIVW  = 7'b0000010,
    S_VSTEP = 7'b0000100,
    S_VACC  = 7'b0001000,
    S_NOISE = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // programmed state
  logic [4:0]    sel_reg_r;
  logic [7:0]    amp_r   [6];
  logic [7:0]    freq_r  [6];
  logic [2:0]    oct_r   [6];
  logic [11:0]   en_r;
  logic [3:0]    nrate_r;
  logic [6:0]    ectl_r  [2];
  logic [5:0]    epos_r  [2];
  logic [9:0]    elev_r  [2];
  logic          mix_r;
  logic [PB-1:0] vph_r   [6];
  logic [PB-1:0] nph_r   [2];
  logic          nlast_r [2];
  logic [15:0]   nsh_r   [2];

  // tick working state
  logic [2:0]              ch_r;
  logic [PB-1:0]           inc_r;
  logic [PB-1:0]           inc0_r;
  logic [PB-1:0]           inc3_r;
  logic                    lvl_r;
  logic signed [SUM_W-1:0] suml_r;
  logic signed [SUM_W-1:0] sumr_r;
  logic [PRD_W-1:0]        prodl_r;
  logic [PRD_W-1:0]        prodr_r;
  logic                    negl_r;
  logic                    negr_r;
  logic                    out_valid_r;
  logic signed [15:0]      outl_r;
  logic signed [15:0]      outr_r;

  logic in_acc;
  logic out_free;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // divider operands for the voice about to be started
  logic                div_start;
  logic [2:0]          ch_sel;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  svtn_pkg::div_stat_t div_st;
  logic [PB-1:0]       div_q;

  assign div_start = (in_acc && in_opcode == svtn_pkg::OP_TICK && mix_r) ||
                     (state_r == S_VACC && ch_r != 3'd5);
  assign ch_sel  = (state_r == S_IDLE) ? 3'd0 : ch_r + 3'd1;
  assign div_num = (NUM_W'(svtn_pkg::FREQ_BASE) << oct_r[ch_sel]) << PB;
  assign div_den = DEN_W'(10'd511 - {2'b00, freq_r[ch_sel]}) * DEN_W'(SAMPLE_RATE_HZ);

  svtn_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (PB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_st),
    .quot  (div_q)
  );

  // envelope steps: external clock on address select, internal during tick
  svtn_pkg::env_upd_t eupd0, eupd1;
  assign eupd0 = svtn_pkg::env_advance(ectl_r[0], epos_r[0]);
  assign eupd1 = svtn_pkg::env_advance(ectl_r[1], epos_r[1]);

  // voice contribution: amp nibble * level * 4095 / 16
  logic          grp;
  logic [9:0]    lev;
  logic [8:0]    pl, pr;
  logic [16:0]   tl, tr;
  logic          nz_on, tn_on;
  assign grp   = (ch_r >= 3'd3);
  assign lev   = elev_r[grp];
  assign pl    = 9'(amp_r[ch_r][3:0] * lev[4:0]);
  assign pr    = 9'(amp_r[ch_r][7:4] * lev[9:5]);
  assign tl    = 17'(((21'(pl) << 12) - 21'(pl)) >> 4);
  assign tr    = 17'(((21'(pr) << 12) - 21'(pr)) >> 4);
  assign nz_on = en_r[6 + ch_r] && nsh_r[grp][0];
  assign tn_on = en_r[ch_r] && lvl_r;

  // final scaling: |sum| / 6 with sign restored and clipped
  logic [SUM_W-1:0]  absl, absr;
  logic [17:0]       ql, qr;
  logic signed [18:0] sl, sr;
  assign absl = suml_r[SUM_W-1] ? SUM_W'(-suml_r) : SUM_W'(suml_r);
  assign absr = sumr_r[SUM_W-1] ? SUM_W'(-sumr_r) : SUM_W'(sumr_r);
  assign ql   = prodl_r[svtn_pkg::RECIP6_SH +: 18];
  assign qr   = prodr_r[svtn_pkg::RECIP6_SH +: 18];
  assign sl   = negl_r ? -$signed({1'b0, ql}) : $signed({1'b0, ql});
  assign sr   = negr_r ? -$signed({1'b0, qr}) : $signed({1'b0, qr});

  function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
    if (x > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -19'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_opcode == svtn_pkg::OP_TICK) begin
          state_nxt = mix_r ? S_DIVW : S_MUL;
        end
      end
      S_DIVW:  if (div_st.done) state_nxt = S_VSTEP;
      S_VSTEP: state_nxt = S_VACC;
      S_VACC:  state_nxt = (ch_r == 3'd5) ? S_NOISE : S_DIVW;
      S_NOISE: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_reg_r   <= '0;
      en_r        <= '0;
      nrate_r     <= '0;
      mix_r       <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        amp_r[i]  <= '0;
        freq_r[i] <= '0;
        oct_r[i]  <= '0;
        vph_r[i]  <= '0;
      end
      for (int g = 0; g < 2; g++) begin
        ectl_r[g]  <= '0;
        epos_r[g]  <= '0;
        elev_r[g]  <= '0;
        nph_r[g]   <= '0;
        nlast_r[g] <= 1'b0;
        nsh_r[g]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // new sample loads as the old one leaves; otherwise drop on accept
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_opcode)
              svtn_pkg::OP_SEL: begin
                sel_reg_r <= in_value[4:0];
                if (in_value[4:0] == svtn_pkg::REG_ENV0 ||
                    in_value[4:0] == svtn_pkg::REG_ENV1) begin
                  if (ectl_r[0][svtn_pkg::ECTL_EXT]) begin
                    epos_r[0] <= eupd0.pos;
                    elev_r[0] <= eupd0.lev;
                  end
                  if (ectl_r[1][svtn_pkg::ECTL_EXT]) begin
                    epos_r[1] <= eupd1.pos;
                    elev_r[1] <= eupd1.lev;
                  end
                end
              end
              svtn_pkg::OP_WR: begin
                if (sel_reg_r <= svtn_pkg::REG_AMP_LAST) begin
                  amp_r[sel_reg_r[2:0]] <= in_value;
                end else if (sel_reg_r >= svtn_pkg::REG_FREQ0 &&
                             sel_reg_r <= svtn_pkg::REG_FREQ_LAST) begin
                  freq_r[sel_reg_r[2:0]] <= in_value;
                end else if (sel_reg_r >= svtn_pkg::REG_OCT0 &&
                             sel_reg_r <= svtn_pkg::REG_OCT_LAST) begin
                  oct_r[{sel_reg_r[1:0], 1'b0}] <= in_value[2:0];
                  oct_r[{sel_reg_r[1:0], 1'b1}] <= in_value[6:4];
                end else if (sel_reg_r == svtn_pkg::REG_TONE_EN) begin
                  en_r[5:0] <= in_value[5:0];
                end else if (sel_reg_r == svtn_pkg::REG_NOISE_EN) begin
                  en_r[11:6] <= in_value[5:0];
                end else if (sel_reg_r == svtn_pkg::REG_NRATE) begin
                  nrate_r <= {in_value[5:4], in_value[1:0]};
                end else if (sel_reg_r == svtn_pkg::REG_ENV0 ||
                             sel_reg_r == svtn_pkg::REG_ENV1) begin
                  ectl_r[sel_reg_r[0]] <= {in_value[7], in_value[5:0]};
                  epos_r[sel_reg_r[0]] <= '0;
                end else if (sel_reg_r == svtn_pkg::REG_MIX) begin
                  mix_r <= in_value[0];
                  if (in_value[1]) begin
                    for (int i = 0; i < 6; i++) vph_r[i] <= '0;
                  end
                end
              end
              svtn_pkg::OP_TICK: begin
                ch_r   <= '0;
                suml_r <= '0;
                sumr_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIVW: begin
          if (div_st.done) inc_r <= div_q;
        end
        S_VSTEP: begin
          // level sampled before the phase advances
          lvl_r       <= ~vph_r[ch_r][PB-1];
          vph_r[ch_r] <= vph_r[ch_r] + inc_r;
          if (ch_r == 3'd0) inc0_r <= inc_r;
          if (ch_r == 3'd3) inc3_r <= inc_r;
          if (ch_r == 3'd1 && !ectl_r[0][svtn_pkg::ECTL_EXT]) begin
            epos_r[0] <= eupd0.pos;
            elev_r[0] <= eupd0.lev;
          end
          if (ch_r == 3'd4 && !ectl_r[1][svtn_pkg::ECTL_EXT]) begin
            epos_r[1] <= eupd1.pos;
            elev_r[1] <= eupd1.lev;
          end
        end
        S_VACC: begin
          suml_r <= suml_r - (nz_on ? SUM_W'(tl >> 1) : SUM_W'(0))
                           + (tn_on ? SUM_W'(tl) : SUM_W'(0));
          sumr_r <= sumr_r - (nz_on ? SUM_W'(tr >> 1) : SUM_W'(0))
                           + (tn_on ? SUM_W'(tr) : SUM_W'(0));
          if (ch_r != 3'd5) ch_r <= ch_r + 3'd1;
        end
        S_NOISE: begin
          for (int g = 0; g < 2; g++) begin
            logic          ff;
            logic [1:0]    nsel;
            logic [PB-1:0] ni;
            ff   = ~nph_r[g][PB-1];
            nsel = nrate_r[2*g +: 2];
            case (nsel)
              2'd0:                 ni = NINC0[PB-1:0];
              2'd1:                 ni = NINC1[PB-1:0];
              2'd2:                 ni = NINC2[PB-1:0];
              svtn_pkg::NSEL_VOICE: ni = (g == 0) ? inc0_r : inc3_r;
              default:              ni = NINC0[PB-1:0];
            endcase
            if (ff && !nlast_r[g]) begin
              nsh_r[g] <= {nsh_r[g][14:0], (nsh_r[g][14] == nsh_r[g][6])};
            end
            nlast_r[g] <= ff;
            nph_r[g]   <= nph_r[g] + ni;
          end
        end
        S_MUL: begin
          prodl_r <= PRD_W'(absl) * PRD_W'(svtn_pkg::RECIP6);
          prodr_r <= PRD_W'(absr) * PRD_W'(svtn_pkg::RECIP6);
          negl_r  <= suml_r[SUM_W-1];
          negr_r  <= sumr_r[SUM_W-1];
        end
        S_FIN: begin
          if (out_free) begin
            outl_r <= sat16(sl);
            outr_r <= sat16(sr);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = outl_r;
  assign out_right_sample = outr_r;

  // divider completion only while a voice is waiting on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIVW)
    else $error("divider finished outside the wait state");

  // a new sample appears only out of the final state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("output raised outside the final state");

  // voice index stays within the six voices during a tick
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ch_r <= 3'd5)
    else $error("voice index out of range");

  // divider not started while still busy
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

@@ test/svtn_sample_checker.sv @@
// ---------------------------------------------------------------------------
// svtn_sample_checker
// Watches both channels of the synth core, keeps its own copy of the
// programmed state, predicts each stereo sample and compares it on arrival.
// ---------------------------------------------------------------------------
`default_nettype none

module svtn_sample_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_value,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_left_sample,
  input  wire logic [15:0] out_right_sample,
  output int               fail_count,
  output int               samples_waiting,
  output int               samples_checked
);
  import svtn_pkg::*;

  localparam int PB = PHASE_BITS_DEF;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } stereo_t;

  stereo_t       sample_q[$];

  logic [4:0]    addr_sel;
  logic [7:0]    amp[6];
  logic [7:0]    freq[6];
  logic [2:0]    oct[6];
  logic [11:0]   mute_mask;   // tone 5..0, noise 11..6
  logic [3:0]    nrate;
  logic [6:0]    ectl[2];
  logic [5:0]    epos[2];
  logic [9:0]    elev[2];
  logic          mix_on;
  logic [PB-1:0] vphase[6];
  logic [PB-1:0] nphase[2];
  logic          nlast[2];
  logic [15:0]   nlfsr[2];

  function automatic logic [3:0] contour(input logic [2:0] mode, input logic [5:0] p);
    case (mode)
      3'd0: return 4'd0;
      3'd1: return 4'd15;
      3'd2: return (p < 16) ? 4'd15 - p[3:0] : 4'd0;
      3'd3: return 4'd15 - p[3:0];
      3'd4: return (p >= 32) ? 4'd0 : (p[4] ? 4'd15 - p[3:0] : p[3:0]);
      3'd5: return p[4] ? 4'd15 - p[3:0] : p[3:0];
      3'd6: return (p < 16) ? p[3:0] : 4'd0;
      default: return p[3:0];
    endcase
  endfunction

  task automatic clock_envelope(input int g);
    logic [3:0] s, m, r;
    if (!ectl[g][ECTL_EN]) begin
      elev[g] = {5'd16, 5'd16};
    end else begin
      epos[g] = (epos[g] == 6'd63) ? 6'd32 : epos[g] + 6'd1;
      s = contour(ectl[g][3:1], epos[g]);
      m = ectl[g][ECTL_B3] ? 4'd14 : 4'd15;
      r = ectl[g][ECTL_REV] ? 4'd15 - s : s;
      elev[g] = {1'b0, r & m, 1'b0, s & m};
    end
  endtask

  function automatic logic [PB-1:0] tone_step(input int v);
    longint unsigned num, den;
    num = (64'd31250 << oct[v]) << PB;
    den = (64'd511 - freq[v]) * 64'd22050;
    return PB'(num / den);
  endfunction

  function automatic int clip16(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  task automatic write_register(input logic [7:0] d);
    int i;
    if (addr_sel <= REG_AMP_LAST) amp[addr_sel] = d;
    else if (addr_sel >= REG_FREQ0 && addr_sel <= REG_FREQ_LAST) freq[addr_sel - REG_FREQ0] = d;
    else if (addr_sel >= REG_OCT0 && addr_sel <= REG_OCT_LAST) begin
      i = addr_sel[1:0] * 2;
      oct[i] = d[2:0];
      oct[i+1] = d[6:4];
    end else if (addr_sel == REG_TONE_EN) mute_mask[5:0] = d[5:0];
    else if (addr_sel == REG_NOISE_EN) mute_mask[11:6] = d[5:0];
    else if (addr_sel == REG_NRATE) nrate = {d[5:4], d[1:0]};
    else if (addr_sel == REG_ENV0 || addr_sel == REG_ENV1) begin
      ectl[addr_sel[0]] = {d[7], d[5:0]};
      epos[addr_sel[0]] = 6'd0;
    end else if (addr_sel == REG_MIX) begin
      mix_on = d[0];
      if (d[1]) for (i = 0; i < 6; i++) vphase[i] = '0;
    end
  endtask

  task automatic predict_tick();
    logic [PB-1:0]   inc[6];
    logic [PB-1:0]   ni;
    logic            hi, ff;
    int              l, r, tl, tr, g, v;
    int unsigned     al, ar;
    longint unsigned hz;
    stereo_t         s;
    l = 0;
    r = 0;
    if (mix_on) begin
      for (v = 0; v < 6; v++) begin
        inc[v] = tone_step(v);
        hi = !vphase[v][PB-1];
        vphase[v] = vphase[v] + inc[v];
        if (v == 1 && !ectl[0][ECTL_EXT]) clock_envelope(0);
        if (v == 4 && !ectl[1][ECTL_EXT]) clock_envelope(1);
        g = v / 3;
        al = 4095 * amp[v][3:0];
        ar = 4095 * amp[v][7:4];
        tl = int'(al * elev[g][4:0] / 16);
        tr = int'(ar * elev[g][9:5] / 16);
        if (mute_mask[6+v] && nlfsr[g][0]) begin
          l -= tl / 2;
          r -= tr / 2;
        end
        if (mute_mask[v] && hi) begin
          l += tl;
          r += tr;
        end
      end
      for (g = 0; g < 2; g++) begin
        if (nrate[2*g +: 2] == NSEL_VOICE) ni = inc[g*3];
        else begin
          hz = (nrate[2*g +: 2] == 2'd0) ? NOISE_HZ0 :
               (nrate[2*g +: 2] == 2'd1) ? NOISE_HZ1 : NOISE_HZ2;
          ni = PB'((hz << PB) / 64'd22050);
        end
        ff = !nphase[g][PB-1];
        if (ff && !nlast[g])
          nlfsr[g] = {nlfsr[g][14:0], nlfsr[g][14] == nlfsr[g][6]};
        nlast[g] = ff;
        nphase[g] = nphase[g] + ni;
      end
      l = clip16(l / 6);
      r = clip16(r / 6);
    end
    s.left = l[15:0];
    s.right = r[15:0];
    sample_q.push_back(s);
  endtask

  assign samples_waiting = sample_q.size();

  always @(posedge clk) begin
    stereo_t e;
    if (!rst_n) begin
      sample_q.delete();
      fail_count <= 0;
      samples_checked <= 0;
      addr_sel = '0;
      mute_mask = '0;
      nrate = '0;
      mix_on = 1'b0;
      for (int i = 0; i < 6; i++) begin
        amp[i] = '0; freq[i] = '0; oct[i] = '0; vphase[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
        ectl[i] = '0; epos[i] = '0; elev[i] = '0;
        nphase[i] = '0; nlast[i] = 1'b0; nlfsr[i] = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        samples_checked <= samples_checked + 1;
        if (sample_q.size() == 0) begin
          $error("unexpected sample L=%0d R=%0d", $signed(out_left_sample),
                 $signed(out_right_sample));
          fail_count <= fail_count + 1;
        end else begin
          e = sample_q.pop_front();
          if (out_left_sample !== e.left || out_right_sample !== e.right) begin
            if (out_left_sample !== e.left)
              $error("left_sample: expected %0d, got %0d", $signed(e.left),
                     $signed(out_left_sample));
            if (out_right_sample !== e.right)
              $error("right_sample: expected %0d, got %0d", $signed(e.right),
                     $signed(out_right_sample));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_SEL: begin
            addr_sel = in_value[4:0];
            if (addr_sel == REG_ENV0 || addr_sel == REG_ENV1) begin
              if (ectl[0][ECTL_EXT]) clock_envelope(0);
              if (ectl[1][ECTL_EXT]) clock_envelope(1);
            end
          end
          OP_WR:   write_register(in_value);
          OP_TICK: predict_tick();
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ test/tb_six_voice_tone_noise_envelope_synth_core.sv @@
// ---------------------------------------------------------------------------
// tb_six_voice_tone_noise_envelope_synth_core
// Drives address, data, tick and reserved-opcode requests into the synth core with bursty
// timing and a stalling receiver; the sample checker does the scoring.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_six_voice_tone_noise_envelope_synth_core;
  import svtn_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_SEL;
  logic [7:0]  in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] out_left_sample, out_right_sample;

  int fail_count, samples_waiting, samples_checked;
  int requests_sent = 0;
  int ticks_sent = 0;
  int burst_left = 0;
  bit hold_off_req = 0;
  bit hold_off_done = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  six_voice_tone_noise_envelope_synth_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_value,
    .out_valid, .out_stall, .out_left_sample, .out_right_sample
  );

  svtn_sample_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_value,
    .out_valid, .out_stall, .out_left_sample, .out_right_sample,
    .fail_count, .samples_waiting, .samples_checked
  );

  // Offer one request and hold it until taken. Bursts of random length,
  // with gaps in between; a zero gap keeps valid high across requests.
  task automatic send_request(input logic [1:0] op, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_opcode <= op;
    in_value  <= val;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  task automatic write_reg(input logic [4:0] addr, input logic [7:0] data);
    send_request(OP_SEL, {3'($urandom_range(0, 7)), addr});
    send_request(OP_WR, data);
  endtask

  // Receiver: changes stall pattern every so often, and once holds off
  // for a long stretch so the output register fills and the input stalls.
  initial begin
    int mode, left_in_mode;
    mode = 0;
    left_in_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off_done = 1;
      end
      if (left_in_mode == 0) begin
        mode = $urandom_range(0, 3);
        left_in_mode = $urandom_range(50, 600);
      end
      left_in_mode--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= (left_in_mode % 16) < 5;
      endcase
    end
  end

  initial begin
    #(4 * 1_500_000);
    $display("six_voice_tone_noise_envelope_synth_core regression: fail");
    $finish;
  end

  initial begin
    int r;
    logic [4:0] addr;
    logic [7:0] data;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme values for each register kind, both envelope clocks, clears
    write_reg(REG_MIX, 8'h01);
    write_reg(5'h00, 8'hFF);
    write_reg(REG_AMP_LAST, 8'h0F);
    write_reg(REG_FREQ0, 8'hFF);
    write_reg(5'h0B, 8'h00);
    write_reg(REG_OCT0, 8'h77);
    write_reg(REG_OCT_LAST, 8'h70);
    write_reg(REG_TONE_EN, 8'hFF);
    write_reg(REG_NOISE_EN, 8'hFF);
    write_reg(REG_NRATE, 8'hFF);
    write_reg(REG_ENV0, 8'hFF);       // enabled, external clock, 3-bit, reversed
    write_reg(REG_ENV1, 8'h8A);
    send_request(OP_TICK, 8'hFF);
    send_request(OP_SEL, {3'b000, REG_ENV0}); // external envelope clock
    send_request(OP_TICK, 8'h00);
    send_request(OP_RSVD, 8'hAA);             // unused opcode, no sample
    write_reg(5'h1F, 8'h55);                  // unused register
    write_reg(REG_MIX, 8'h03);                // mix on, clear phases
    send_request(OP_TICK, 8'h00);
    write_reg(REG_MIX, 8'h00);
    send_request(OP_TICK, 8'h00);             // mix off: zero sample
    write_reg(REG_MIX, 8'h01);

    // random: mostly well-formed address/data pairs and ticks
    while (requests_sent < 650) begin
      if (requests_sent >= 300) hold_off_req = 1;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        addr = ($urandom_range(0, 9) == 0) ? 5'($urandom) :
               (($urandom_range(0, 19) == 0) ? REG_MIX :
               5'($urandom_range(0, 1) ? $urandom_range(0, 5) + 8 * $urandom_range(0, 1)
                                       : $urandom_range(16, 25)));
        data = 8'($urandom);
        if (addr == REG_MIX && $urandom_range(0, 9) != 0) data[0] = 1'b1;
        write_reg(addr, data);
      end else if (r < 88) begin
        send_request(OP_TICK, 8'($urandom));
      end else if (r < 95) begin
        send_request(OP_SEL, {3'($urandom), 4'b1100, 1'($urandom)});
      end else if (r < 98) begin
        send_request(OP_WR, 8'($urandom));
      end else begin
        send_request(OP_RSVD, 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (samples_waiting != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("%0d requests sent, %0d of them ticks; %0d samples compared",
             requests_sent, ticks_sent, samples_checked);
    $display("covered all registers, both envelope clocks, noise, mix on/off, long hold-off");
    if (fail_count == 0 && samples_waiting == 0) begin
      $display("six_voice_tone_noise_envelope_synth_core regression: pass");
    end else begin
      $display("six_voice_tone_noise_envelope_synth_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/svtn_pkg.sv
rtl/core/svtn_div.sv
rtl/core/six_voice_tone_noise_envelope_synth_core.sv
test/svtn_sample_checker.sv
test/tb_six_voice_tone_noise_envelope_synth_core.sv
